FILE: hw/rtl/dalt_pkg.sv
// Shared types, widths and helpers for the dual-axis light tracker servo core.
// No dependencies; imported by every module of the block.
package dalt_pkg;

  localparam int unsigned AngleW    = 8;
  localparam int unsigned LightW    = 8;
  localparam int unsigned SumW      = LightW + 1;
  localparam int unsigned DeadbandW = 9;
  localparam int unsigned PeriodW   = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned OnTimeW   = 5;

  localparam int unsigned MaxAngleDefault = 180;
  localparam int unsigned PanResetAngle   = 180;
  localparam int unsigned TiltResetAngle  = 90;
  localparam int unsigned DeadbandReset   = 20;
  localparam int unsigned PeriodReset     = 117;

  // on-time = floor((angle + 180) / 27), done as multiply by 2^15/27 rounded up
  localparam int unsigned OnTimeBias  = 180;
  localparam int unsigned OnTimeRecip = 1214;
  localparam int unsigned OnTimeShift = 15;
  localparam int unsigned OnTimeProdW = SumW + 11;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_DEADBAND = 1'b0,
    CFG_PERIOD   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              pan_pulse;
    logic              tilt_pulse;
    logic [AngleW-1:0] pan_angle;
    logic [AngleW-1:0] tilt_angle;
  } result_t;

  function automatic logic [OnTimeW-1:0] on_time(input logic [AngleW-1:0] angle);
    logic [SumW-1:0]        x;
    logic [OnTimeProdW-1:0] prod;
    x    = SumW'(angle) + SumW'(OnTimeBias);
    prod = OnTimeProdW'(x) * OnTimeProdW'(OnTimeRecip);
    return OnTimeW'(prod >> OnTimeShift);
  endfunction

endpackage

FILE: hw/rtl/dual_axis_light_tracker_servo_core.sv
// Top level of the dual-axis light tracker servo core: handshakes, config
// registers, input and result registers. Depends on dalt_pkg, dalt_axis_step,
// dalt_pulse_chan.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | to core   | in_valid_i/in_stall_o | command, four light readings
//  out     | from core | out_valid_o/out_stall_i | pulse levels, pan/tilt angles
//  cfg     | to core   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One request per cycle unless held by out_stall_i. Input register, then result
//  register. State updates as a request moves into the result register.
//  Reset (async, active low): pan 180, tilt 90, counters and levels 0,
//  deadband 20, period 117. Config always ready, one write per cycle.
//  in_stall_o rises only when the input register is full and the result
//  register is held by out_stall_i.
module dual_axis_light_tracker_servo_core #(
  parameter int unsigned MaxAngle = dalt_pkg::MaxAngleDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [dalt_pkg::LightW-1:0]    light_top_left_i,
  input  logic [dalt_pkg::LightW-1:0]    light_top_right_i,
  input  logic [dalt_pkg::LightW-1:0]    light_bottom_right_i,
  input  logic [dalt_pkg::LightW-1:0]    light_bottom_left_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pan_pulse_o,
  output logic                           tilt_pulse_o,
  output logic [dalt_pkg::AngleW-1:0]    pan_angle_o,
  output logic [dalt_pkg::AngleW-1:0]    tilt_angle_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [dalt_pkg::DeadbandW-1:0] cfg_data_i
);
  import dalt_pkg::*;

  // config registers
  logic [DeadbandW-1:0] deadband_q;
  logic [PeriodW-1:0]   period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DeadbandW'(DeadbandReset);
      period_q   <= PeriodW'(PeriodReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEADBAND: deadband_q <= cfg_data_i;
        CFG_PERIOD:   period_q   <= PeriodW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid_q, out_valid_q;
  logic in_acc, out_ready, s1_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register
  logic              cmd_q;
  logic [LightW-1:0] tl_q, tr_q, br_q, bl_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      tl_q  <= light_top_left_i;
      tr_q  <= light_top_right_i;
      br_q  <= light_bottom_right_i;
      bl_q  <= light_bottom_left_i;
    end
  end

  // datapath
  logic              sample_en, tick_en;
  logic [SumW-1:0]   left_sum, right_sum, top_sum, bottom_sum;
  logic [AngleW-1:0] pan_angle, tilt_angle, pan_angle_d, tilt_angle_d;
  logic              pan_level_d, tilt_level_d;

  assign sample_en  = s1_fire && (cmd_e'(cmd_q) == CMD_SAMPLE);
  assign tick_en    = s1_fire && (cmd_e'(cmd_q) == CMD_TICK);
  assign left_sum   = SumW'(tl_q) + SumW'(bl_q);
  assign right_sum  = SumW'(tr_q) + SumW'(br_q);
  assign top_sum    = SumW'(tl_q) + SumW'(tr_q);
  assign bottom_sum = SumW'(bl_q) + SumW'(br_q);

  dalt_axis_step #(
    .MaxAngle   (MaxAngle),
    .ResetAngle (PanResetAngle)
  ) u_pan_axis (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (sample_en),
    .up_sum_i     (right_sum),
    .down_sum_i   (left_sum),
    .deadband_i   (deadband_q),
    .angle_o      (pan_angle),
    .angle_next_o (pan_angle_d)
  );

  dalt_axis_step #(
    .MaxAngle   (MaxAngle),
    .ResetAngle (TiltResetAngle)
  ) u_tilt_axis (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (sample_en),
    .up_sum_i     (top_sum),
    .down_sum_i   (bottom_sum),
    .deadband_i   (deadband_q),
    .angle_o      (tilt_angle),
    .angle_next_o (tilt_angle_d)
  );

  dalt_pulse_chan u_pan_pulse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_en),
    .angle_i      (pan_angle),
    .period_i     (period_q),
    .level_next_o (pan_level_d)
  );

  dalt_pulse_chan u_tilt_pulse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_en),
    .angle_i      (tilt_angle),
    .period_i     (period_q),
    .level_next_o (tilt_level_d)
  );

  // result register
  result_t res_q, res_d;

  always_comb begin
    res_d.pan_pulse  = pan_level_d;
    res_d.tilt_pulse = tilt_level_d;
    res_d.pan_angle  = pan_angle_d;
    res_d.tilt_angle = tilt_angle_d;
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) res_q <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pan_pulse_o  = res_q.pan_pulse;
  assign tilt_pulse_o = res_q.tilt_pulse;
  assign pan_angle_o  = res_q.pan_angle;
  assign tilt_angle_o = res_q.tilt_angle;

  // stall only while a request waits behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free pipeline slot");

  // a request leaving the input register shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q && (res_q.pan_angle == pan_angle))
    else $error("result lost or angle mismatch");

endmodule

FILE: hw/rtl/dalt_axis_step.sv
// One tracker axis: holds the angle and moves it at most one degree per sample.
// Depends on dalt_pkg.
module dalt_axis_step #(
  parameter int unsigned MaxAngle   = dalt_pkg::MaxAngleDefault,
  parameter int unsigned ResetAngle = dalt_pkg::PanResetAngle
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_en_i,
  input  logic [dalt_pkg::SumW-1:0]      up_sum_i,
  input  logic [dalt_pkg::SumW-1:0]      down_sum_i,
  input  logic [dalt_pkg::DeadbandW-1:0] deadband_i,
  output logic [dalt_pkg::AngleW-1:0]    angle_o,
  output logic [dalt_pkg::AngleW-1:0]    angle_next_o
);
  import dalt_pkg::*;

  localparam logic [AngleW-1:0] MaxAngleL = AngleW'(MaxAngle);

  logic [AngleW-1:0] angle_q, angle_d;
  logic [SumW-1:0]   up_diff, down_diff;
  logic              go_up, go_down;

  // true difference, 9 bits, no wrap
  assign up_diff   = up_sum_i - down_sum_i;
  assign down_diff = down_sum_i - up_sum_i;
  assign go_up     = (up_sum_i > down_sum_i) && (DeadbandW'(up_diff) >= deadband_i);
  assign go_down   = (down_sum_i > up_sum_i) && (DeadbandW'(down_diff) >= deadband_i);

  always_comb begin
    angle_d = angle_q;
    if (step_en_i) begin
      if (go_up) begin
        if (angle_q < MaxAngleL) angle_d = angle_q + AngleW'(1);
      end else if (go_down) begin
        if (angle_q != '0) angle_d = angle_q - AngleW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= AngleW'(ResetAngle);
    end else begin
      angle_q <= angle_d;
    end
  end

  assign angle_o      = angle_q;
  assign angle_next_o = angle_d;

  // angle only moves on a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(step_en_i) |-> angle_q == $past(angle_q))
    else $error("axis angle moved without a sample");

endmodule

FILE: hw/rtl/dalt_pulse_chan.sv
// One servo pulse channel: tick counter, on-time compare and output level.
// Depends on dalt_pkg.
module dalt_pulse_chan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic [dalt_pkg::AngleW-1:0]  angle_i,
  input  logic [dalt_pkg::PeriodW-1:0] period_i,
  output logic                         level_next_o
);
  import dalt_pkg::*;

  logic [CountW-1:0]  count_q, count_d, count_inc;
  logic               level_q, level_d;
  logic [OnTimeW-1:0] on_ticks;

  assign on_ticks  = on_time(angle_i);
  assign count_inc = count_q + CountW'(1);

  always_comb begin
    count_d = count_q;
    level_d = level_q;
    if (tick_i) begin
      count_d = count_inc;
      if (count_inc <= CountW'(on_ticks)) begin
        level_d = 1'b1;
      end else begin
        level_d = 1'b0;
        if (count_inc == CountW'(period_i)) count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
    end else begin
      count_q <= count_d;
      level_q <= level_d;
    end
  end

  assign level_next_o = level_d;

  // counter and level hold between ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(tick_i) |-> (count_q == $past(count_q)) && (level_q == $past(level_q)))
    else $error("pulse channel changed without a tick");

endmodule
